// File: rtl/ibmw_pkg.sv
// ----------------------------------------------------------------------------
// ibmw_pkg
// Shared types and constants of the indirect block map walker: input mode
// codes, pointer slot numbers, the command that travels from the front
// to the back, and the result beat.
// ----------------------------------------------------------------------------
package ibmw_pkg;

    // Inode pointer slots.
    localparam int POINTER_SLOTS    = 15;
    localparam int DIRECT_SLOTS_DEF = 12;
    localparam logic [3:0] SINGLE_SLOT = 4'd12;
    localparam logic [3:0] DOUBLE_SLOT = 4'd13;
    localparam logic [3:0] TRIPLE_SLOT = 4'd14;

    // Queue depths between the parts.
    localparam int MID_DEPTH_DEF = 4;
    localparam int OUT_DEPTH_DEF = 4;

    // Largest log block size that is honored; larger values clamp to it.
    localparam logic [2:0] MAX_LOG = 3'd6;

    // Input mode codes.
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_MAP  = 2'd1;
    localparam logic [1:0] MODE_WORD = 2'd2;

    // Result kinds.
    localparam logic KIND_REQUEST = 1'b0;
    localparam logic KIND_DONE    = 1'b1;

    // Walk depths.
    localparam logic [1:0] LEVELS_IDLE   = 2'd0;
    localparam logic [1:0] LEVELS_SINGLE = 2'd1;
    localparam logic [1:0] LEVELS_DOUBLE = 2'd2;
    localparam logic [1:0] LEVELS_TRIPLE = 2'd3;

    // Operations that the back carries out.
    typedef enum logic [2:0] {
        OP_LOAD,
        OP_DIRECT,
        OP_WALK,
        OP_RANGE,
        OP_WORD
    } op_t;

    // Classified item from the front.
    typedef struct packed {
        op_t         op;
        logic [3:0]  slot;
        logic [31:0] value;
        logic [1:0]  levels;
        logic [13:0] first;
        logic [13:0] second;
        logic [13:0] third;
    } cmd_t;

    // One result beat.
    typedef struct packed {
        logic        kind;
        logic [31:0] block_num;
        logic [13:0] word_index;
        logic        sparse;
        logic        out_of_range;
    } res_t;

endpackage

// File: rtl/ibmw_fifo.sv
// ----------------------------------------------------------------------------
// ibmw_fifo
// Small first-in first-out queue built from registers, with full and empty
// flags taken from a registered fill count.
// ----------------------------------------------------------------------------
module ibmw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ibmw_pkg::MID_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer wrap and fill count.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset; an entry is read only after it was written.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/ibmw_front.sv
// ----------------------------------------------------------------------------
// ibmw_front
// Accepts input beats, drops unknown modes and loads to a missing slot, and classifies map
// requests into direct, single, double or triple indirect, or out of range,
// with the pointer index of every level worked out by shifts and masks.
// ----------------------------------------------------------------------------
module ibmw_front #(
    parameter int DIRECT_SLOTS = ibmw_pkg::DIRECT_SLOTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [1:0]         mode,
    input  logic [3:0]         slot,
    input  logic [31:0]        value,
    output logic               full,
    input  logic [2:0]         log_size,
    output logic               cmd_push,
    output ibmw_pkg::cmd_t     cmd,
    input  logic               cmd_full
);

    logic        a_valid_reg;
    logic        a_valid_next;
    logic [1:0]  a_mode_reg;
    logic [3:0]  a_slot_reg;
    logic [31:0] a_value_reg;
    logic        a_direct_reg;
    logic [31:0] a_lb_reg;

    logic        advance;
    logic        accept;
    logic        keep;

    logic [3:0]  sh;
    logic [4:0]  sh2;
    logic [5:0]  sh3;
    logic [42:0] t1;
    logic [42:0] t2;
    logic [42:0] t3;
    logic [42:0] lb_wide;
    logic [31:0] lb1;
    logic [31:0] lb2;
    logic [13:0] mask;
    logic [31:0] lb1_hi;
    logic [31:0] lb2_mid;
    logic [31:0] lb2_hi;

    // The holding stage moves on whenever it is empty or the queue has room.
    assign advance  = !a_valid_reg || !cmd_full;
    assign full     = !advance;
    assign accept   = push && advance;
    assign cmd_push = a_valid_reg && !cmd_full;

    // Unknown modes and loads to a missing slot leave no trace at all.
    assign keep = (mode == ibmw_pkg::MODE_MAP) || (mode == ibmw_pkg::MODE_WORD) ||
                  ((mode == ibmw_pkg::MODE_LOAD) && (slot < 4'(ibmw_pkg::POINTER_SLOTS)));

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (advance)
        begin
            a_valid_next = accept && keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    // Payload of the holding stage, with the direct range already removed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_mode_reg   <= mode;
            a_slot_reg   <= slot;
            a_value_reg  <= value;
            a_direct_reg <= (value < 32'(DIRECT_SLOTS));
            a_lb_reg     <= value - 32'(DIRECT_SLOTS);
        end
    end

    // Range bounds are sums of distinct powers of two, so they are plain ORs.
    assign sh      = 4'd8 + {1'b0, log_size};
    assign sh2     = {sh, 1'b0};
    assign sh3     = 6'(sh) + 6'(sh2);
    assign t1      = 43'(1) << sh;
    assign t2      = t1 | (43'(1) << sh2);
    assign t3      = t2 | (43'(1) << sh3);
    assign lb_wide = 43'(a_lb_reg);
    assign lb1     = a_lb_reg - t1[31:0];
    assign lb2     = a_lb_reg - t2[31:0];
    assign mask    = t1[13:0] - 14'd1;
    assign lb1_hi  = lb1 >> sh;
    assign lb2_mid = lb2 >> sh;
    assign lb2_hi  = lb2 >> sh2;

    // Build the command for the back.
    always_comb
    begin
        cmd        = '0;
        cmd.op     = ibmw_pkg::OP_LOAD;
        cmd.slot   = a_slot_reg;
        cmd.value  = a_value_reg;
        case (a_mode_reg)
            ibmw_pkg::MODE_LOAD:
            begin
                cmd.op = ibmw_pkg::OP_LOAD;
            end
            ibmw_pkg::MODE_WORD:
            begin
                cmd.op = ibmw_pkg::OP_WORD;
            end
            ibmw_pkg::MODE_MAP:
            begin
                if (a_direct_reg)
                begin
                    cmd.op   = ibmw_pkg::OP_DIRECT;
                    cmd.slot = a_value_reg[3:0];
                end
                else if (lb_wide < t1)
                begin
                    cmd.op     = ibmw_pkg::OP_WALK;
                    cmd.slot   = ibmw_pkg::SINGLE_SLOT;
                    cmd.levels = ibmw_pkg::LEVELS_SINGLE;
                    cmd.first  = a_lb_reg[13:0];
                end
                else if (lb_wide < t2)
                begin
                    cmd.op     = ibmw_pkg::OP_WALK;
                    cmd.slot   = ibmw_pkg::DOUBLE_SLOT;
                    cmd.levels = ibmw_pkg::LEVELS_DOUBLE;
                    cmd.first  = lb1_hi[13:0];
                    cmd.second = lb1[13:0] & mask;
                end
                else if (lb_wide < t3)
                begin
                    cmd.op     = ibmw_pkg::OP_WALK;
                    cmd.slot   = ibmw_pkg::TRIPLE_SLOT;
                    cmd.levels = ibmw_pkg::LEVELS_TRIPLE;
                    cmd.first  = lb2_hi[13:0];
                    cmd.second = lb2_mid[13:0] & mask;
                    cmd.third  = lb2[13:0] & mask;
                end
                else
                begin
                    cmd.op = ibmw_pkg::OP_RANGE;
                end
            end
            default:
            begin
                cmd.op = ibmw_pkg::OP_LOAD;
            end
        endcase
    end

endmodule

// File: rtl/ibmw_back.sv
// ----------------------------------------------------------------------------
// ibmw_back
// Carries out classified commands in order: owns the inode pointer table
// and the walk state, and produces at most one result beat per command.
// ----------------------------------------------------------------------------
module ibmw_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_empty,
    input  ibmw_pkg::cmd_t cmd,
    output logic           cmd_pop,
    input  logic           res_full,
    output logic           res_push,
    output ibmw_pkg::res_t res
);

    logic [31:0] ptr_table_reg [ibmw_pkg::POINTER_SLOTS];
    logic [1:0]  levels_reg;
    logic [1:0]  levels_next;
    logic [13:0] second_reg;
    logic [13:0] second_next;
    logic [13:0] third_reg;
    logic [13:0] third_next;
    logic        fire;
    logic [31:0] root;

    // Finished result; a zero block is a hole.
    function automatic ibmw_pkg::res_t done_beat(input logic [31:0] addr);
        ibmw_pkg::res_t r;
        r              = '0;
        r.kind         = ibmw_pkg::KIND_DONE;
        r.block_num    = addr;
        r.sparse       = (addr == 32'd0);
        return r;
    endfunction

    // Read request for one pointer word.
    function automatic ibmw_pkg::res_t request_beat(input logic [31:0] addr,
                                                    input logic [13:0] idx);
        ibmw_pkg::res_t r;
        r            = '0;
        r.kind       = ibmw_pkg::KIND_REQUEST;
        r.block_num  = addr;
        r.word_index = idx;
        return r;
    endfunction

    assign fire    = !cmd_empty && !res_full;
    assign cmd_pop = fire;
    assign root    = ptr_table_reg[cmd.slot];

    // Walk step and result selection.
    always_comb
    begin
        levels_next = levels_reg;
        second_next = second_reg;
        third_next  = third_reg;
        res_push    = 1'b0;
        res         = '0;
        if (fire)
        begin
            case (cmd.op)
                ibmw_pkg::OP_LOAD:
                begin
                    res_push = 1'b0;
                end
                ibmw_pkg::OP_DIRECT:
                begin
                    levels_next = ibmw_pkg::LEVELS_IDLE;
                    second_next = '0;
                    third_next  = '0;
                    res_push    = 1'b1;
                    res         = done_beat(root);
                end
                ibmw_pkg::OP_WALK:
                begin
                    second_next = cmd.second;
                    third_next  = cmd.third;
                    res_push    = 1'b1;
                    if (root == 32'd0)
                    begin
                        levels_next = ibmw_pkg::LEVELS_IDLE;
                        res         = done_beat(32'd0);
                    end
                    else
                    begin
                        levels_next = cmd.levels;
                        res         = request_beat(root, cmd.first);
                    end
                end
                ibmw_pkg::OP_RANGE:
                begin
                    levels_next      = ibmw_pkg::LEVELS_IDLE;
                    second_next      = '0;
                    third_next       = '0;
                    res_push         = 1'b1;
                    res.kind         = ibmw_pkg::KIND_DONE;
                    res.out_of_range = 1'b1;
                end
                ibmw_pkg::OP_WORD:
                begin
                    if (levels_reg == ibmw_pkg::LEVELS_IDLE)
                    begin
                        res_push = 1'b0;
                    end
                    else if (levels_reg == ibmw_pkg::LEVELS_SINGLE)
                    begin
                        levels_next = ibmw_pkg::LEVELS_IDLE;
                        res_push    = 1'b1;
                        res         = done_beat(cmd.value);
                    end
                    else if (cmd.value == 32'd0)
                    begin
                        levels_next = ibmw_pkg::LEVELS_IDLE;
                        res_push    = 1'b1;
                        res         = done_beat(32'd0);
                    end
                    else
                    begin
                        res_push = 1'b1;
                        res      = request_beat(cmd.value, second_reg);
                        if (levels_reg == ibmw_pkg::LEVELS_TRIPLE)
                        begin
                            second_next = third_reg;
                            levels_next = ibmw_pkg::LEVELS_DOUBLE;
                        end
                        else
                        begin
                            levels_next = ibmw_pkg::LEVELS_SINGLE;
                        end
                    end
                end
                default:
                begin
                    res_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg <= ibmw_pkg::LEVELS_IDLE;
            second_reg <= '0;
            third_reg  <= '0;
        end
        else
        begin
            levels_reg <= levels_next;
            second_reg <= second_next;
            third_reg  <= third_next;
        end
    end

    // Pointer table holds whatever was loaded; it has no reset value.
    always_ff @(posedge clk)
    begin
        if (fire && (cmd.op == ibmw_pkg::OP_LOAD))
        begin
            ptr_table_reg[cmd.slot] <= cmd.value;
        end
    end

endmodule

// File: rtl/indirect_block_map_walker.sv
// ----------------------------------------------------------------------------
// indirect_block_map_walker
// Maps a file's logical block to a physical block through the inode's
// direct and single, double and triple indirect pointers, issuing one
// pointer word read request per indirect level.
//
//   Channel   Handshake            Beat contents
//   input     push / full          mode, slot, value
//   result    empty / pop          kind, block_num, word_index, sparse,
//                                  out_of_range
//   config    cfg_we               cfg_wdata (log block size)
//
// One input beat is taken every cycle while the result queue drains.
// An input beat is registered in the front's holding stage, then in the
// command queue, and the back writes its result into the result queue.
// Either side may stall; the command and result queues hold the work.
// Reset clears the queues and the walk state; the pointer table is not
// cleared and slots must be loaded before they are mapped.
// ----------------------------------------------------------------------------
module indirect_block_map_walker #(
    parameter int DIRECT_SLOTS = ibmw_pkg::DIRECT_SLOTS_DEF,
    parameter int MID_DEPTH    = ibmw_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH    = ibmw_pkg::OUT_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  mode,
    input  logic [3:0]  slot,
    input  logic [31:0] value,
    output logic        empty,
    input  logic        pop,
    output logic        kind,
    output logic [31:0] block_num,
    output logic [13:0] word_index,
    output logic        sparse,
    output logic        out_of_range
);

    logic [2:0]     log_size_reg;
    logic [2:0]     log_size;
    logic           cmd_push;
    logic           cmd_full;
    logic           cmd_empty;
    logic           cmd_pop;
    ibmw_pkg::cmd_t cmd_in;
    ibmw_pkg::cmd_t cmd_out;
    logic           res_push;
    logic           res_full;
    ibmw_pkg::res_t res_in;
    ibmw_pkg::res_t res_out;

    // Log block size register; values above the largest supported clamp.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            log_size_reg <= '0;
        end
        else if (cfg_we)
        begin
            log_size_reg <= cfg_wdata;
        end
    end

    assign log_size = (log_size_reg > ibmw_pkg::MAX_LOG) ? ibmw_pkg::MAX_LOG : log_size_reg;

    // Front: accept and classify.
    ibmw_front #(
        .DIRECT_SLOTS(DIRECT_SLOTS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .mode     (mode),
        .slot     (slot),
        .value    (value),
        .full     (full),
        .log_size (log_size),
        .cmd_push (cmd_push),
        .cmd      (cmd_in),
        .cmd_full (cmd_full)
    );

    // Command queue between front and back.
    ibmw_fifo #(
        .WIDTH($bits(ibmw_pkg::cmd_t)),
        .DEPTH(MID_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_in),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_out),
        .empty   (cmd_empty)
    );

    // Back: pointer table and walk.
    ibmw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    // Result queue toward the consumer.
    ibmw_fifo #(
        .WIDTH($bits(ibmw_pkg::res_t)),
        .DEPTH(OUT_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_out),
        .empty   (empty)
    );

    assign kind         = res_out.kind;
    assign block_num    = res_out.block_num;
    assign word_index   = res_out.word_index;
    assign sparse       = res_out.sparse;
    assign out_of_range = res_out.out_of_range;

    // A read request never names block zero and never carries a flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind == ibmw_pkg::KIND_REQUEST)) |->
            (!sparse && !out_of_range && (block_num != 32'd0)))
        else $error("read request with a flag or a zero block");

    // A hole is a finished mapping of block zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && sparse) |->
            ((kind == ibmw_pkg::KIND_DONE) && (block_num == 32'd0) && !out_of_range))
        else $error("hole beat is malformed");

    // A waiting result is not lost without a pop.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result vanished without a pop");

endmodule

// File: tb/sv/indirect_block_map_walker_test.sv
// ----------------------------------------------------------------------------
// indirect_block_map_walker_test
// Self-checking bench for the inode block map walker. A short table of
// directed beats covers holes, the ends of each indirect range and the
// inputs that the walker ignores. Random walks under every block size follow.
// Each accepted input beat steps a local copy of the walker, which queues the
// expected result beat. Each popped result is compared with it field by field.
// ----------------------------------------------------------------------------
module indirect_block_map_walker_test;
    import ibmw_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         PHASE_BEATS = 190;
    localparam int         HOLD_AFTER  = 300;
    localparam int         HOLD_CYCLES = 400;
    localparam int         SETTLE      = 8;
    localparam int         MAX_PRINTS  = 40;
    localparam int         CALM_PHASE  = 3;
    localparam logic [1:0] MODE_BAD    = 2'd3;
    localparam logic [3:0] NO_SLOT     = 4'd15;

    // One directed beat, with an optional expected result typed in by hand.
    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  slot;
        logic [31:0] value;
        logic        typed;
        logic        has_res;
        res_t        res;
    } plan_row_t;

    // Directed beats, all at the reset block size of 1 KiB.
    localparam int DIRECTED_ROWS = 27;
    localparam plan_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{MODE_WORD, 4'd0,        32'd5,          1'b1, 1'b0, '0},
        '{MODE_BAD,  NO_SLOT,     32'hFFFF_FFFF,  1'b1, 1'b0, '0},
        '{MODE_LOAD, NO_SLOT,     32'h0000_0123,  1'b1, 1'b0, '0},
        '{MODE_LOAD, 4'd0,        32'd0,          1'b0, 1'b0, '0},
        '{MODE_LOAD, 4'd11,       32'hFFFF_FFFF,  1'b0, 1'b0, '0},
        '{MODE_LOAD, SINGLE_SLOT, 32'd0,          1'b0, 1'b0, '0},
        '{MODE_LOAD, DOUBLE_SLOT, 32'h0000_2000,  1'b0, 1'b0, '0},
        '{MODE_LOAD, TRIPLE_SLOT, 32'h0000_3000,  1'b0, 1'b0, '0},
        '{MODE_MAP,  4'd0,        32'd0,          1'b1, 1'b1,
          '{KIND_DONE, 32'd0, 14'd0, 1'b1, 1'b0}},
        '{MODE_MAP,  4'd0,        32'd11,         1'b1, 1'b1,
          '{KIND_DONE, 32'hFFFF_FFFF, 14'd0, 1'b0, 1'b0}},
        '{MODE_MAP,  4'd0,        32'd12,         1'b1, 1'b1,
          '{KIND_DONE, 32'd0, 14'd0, 1'b1, 1'b0}},
        '{MODE_LOAD, SINGLE_SLOT, 32'h0000_1000,  1'b0, 1'b0, '0},
        '{MODE_MAP,  4'd0,        32'd267,        1'b1, 1'b1,
          '{KIND_REQUEST, 32'h0000_1000, 14'd255, 1'b0, 1'b0}},
        '{MODE_LOAD, 4'd5,        32'h0000_0077,  1'b0, 1'b0, '0},
        '{MODE_WORD, 4'd0,        32'd0,          1'b0, 1'b0, '0},
        '{MODE_MAP,  4'd0,        32'd268,        1'b0, 1'b0, '0},
        '{MODE_MAP,  4'd0,        32'd65803,      1'b0, 1'b0, '0},
        '{MODE_WORD, 4'd0,        32'h0000_ABCD,  1'b0, 1'b0, '0},
        '{MODE_WORD, 4'd0,        32'hFFFF_FFFF,  1'b0, 1'b0, '0},
        '{MODE_MAP,  4'd0,        32'd65804,      1'b0, 1'b0, '0},
        '{MODE_WORD, 4'd0,        32'd0,          1'b0, 1'b0, '0},
        '{MODE_MAP,  4'd0,        32'd16843019,   1'b0, 1'b0, '0},
        '{MODE_WORD, 4'd0,        32'h0000_0011,  1'b0, 1'b0, '0},
        '{MODE_WORD, 4'd0,        32'h0000_0022,  1'b0, 1'b0, '0},
        '{MODE_WORD, 4'd0,        32'h0000_0033,  1'b0, 1'b0, '0},
        '{MODE_MAP,  4'd0,        32'd16843020,   1'b1, 1'b1,
          '{KIND_DONE, 32'd0, 14'd0, 1'b0, 1'b1}},
        '{MODE_MAP,  4'd0,        32'hFFFF_FFFF,  1'b1, 1'b1,
          '{KIND_DONE, 32'd0, 14'd0, 1'b0, 1'b1}}
    };

    // Block size settings of the random phases; seven clamps to six.
    localparam logic [2:0] SIZE_PLAN [8] = '{3'd0, 3'd6, 3'd7, 3'd3,
                                             3'd1, 3'd5, 3'd2, 3'd4};

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        cfg_we       = 1'b0;
    logic [2:0]  cfg_wdata    = 3'd0;
    logic        push         = 1'b0;
    logic [1:0]  mode         = MODE_LOAD;
    logic [3:0]  slot         = 4'd0;
    logic [31:0] value        = 32'd0;
    logic        pop          = 1'b0;
    logic        full;
    logic        empty;
    logic        kind;
    logic [31:0] block_num;
    logic [13:0] word_index;
    logic        sparse;
    logic        out_of_range;

    // Local copy of the walker state.
    logic [31:0] ptr_slots [POINTER_SLOTS];
    logic [1:0]  walk_levels = LEVELS_IDLE;
    logic [13:0] next_idx    = 14'd0;
    logic [13:0] last_idx    = 14'd0;
    logic [2:0]  blk_log     = 3'd0;

    res_t pending_results [$];
    int   gap_pct      = 8;
    int   cycles       = 0;
    int   errors       = 0;
    int   beats_in     = 0;
    int   results_seen = 0;
    int   requests     = 0;
    int   holes        = 0;
    int   beyond       = 0;

    indirect_block_map_walker dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .slot         (slot),
        .value        (value),
        .empty        (empty),
        .pop          (pop),
        .kind         (kind),
        .block_num    (block_num),
        .word_index   (word_index),
        .sparse       (sparse),
        .out_of_range (out_of_range)
    );

    // Clock with a period of 12 time units.
    initial
    begin
        forever #6 clk = ~clk;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results pending.",
                     cycles, pending_results.size());
            $display("indirect_block_map_walker_test NOT OK");
            $finish;
        end
    end

    task automatic flag_error(input string what);
        if (errors < MAX_PRINTS)
            $display("ERROR at cycle %0d: %s", cycles, what);
        errors++;
    endtask

    // The walk ends here: a physical block of zero is a hole.
    function automatic res_t finished(input logic [31:0] phys);
        walk_levels = LEVELS_IDLE;
        return '{KIND_DONE, phys, 14'd0, phys == 32'd0, 1'b0};
    endfunction

    // Start a walk at an inode root pointer; a zero root is a hole.
    function automatic res_t descend(input logic [31:0] root, input logic [63:0] first,
                                     input logic [1:0] levels);
        if (root == 32'd0)
            return finished(32'd0);
        walk_levels = levels;
        return '{KIND_REQUEST, root, first[13:0], 1'b0, 1'b0};
    endfunction

    // Step the local walker by one input beat and work out its result.
    task automatic resolve_beat(input logic [1:0] m, input logic [3:0] s,
                                input logic [31:0] v, output bit has, output res_t r);
        int unsigned sh;
        logic [63:0] per_blk;
        logic [63:0] mask;
        logic [63:0] base2;
        logic [63:0] base3;
        logic [63:0] top;
        logic [63:0] lb;
        logic [63:0] part;
        logic [63:0] upper;
        has     = 1'b0;
        r       = '0;
        sh      = 8 + ((blk_log > MAX_LOG) ? MAX_LOG : blk_log);
        per_blk = 64'd1 << sh;
        mask    = per_blk - 64'd1;
        base2   = 64'(DIRECT_SLOTS_DEF) + per_blk;
        base3   = base2 + (per_blk << sh);
        top     = base3 + (per_blk << (2 * sh));
        lb      = {32'd0, v};
        case (m)
            MODE_LOAD:
            begin
                if (s < POINTER_SLOTS)
                    ptr_slots[s] = v;
            end
            MODE_MAP:
            begin
                // A new map request drops any walk in progress.
                has         = 1'b1;
                walk_levels = LEVELS_IDLE;
                next_idx    = 14'd0;
                last_idx    = 14'd0;
                if (lb < 64'(DIRECT_SLOTS_DEF))
                    r = finished(ptr_slots[lb[3:0]]);
                else if (lb < base2)
                    r = descend(ptr_slots[SINGLE_SLOT], lb - 64'(DIRECT_SLOTS_DEF),
                                LEVELS_SINGLE);
                else if (lb < base3)
                begin
                    part     = lb - base2;
                    next_idx = part[13:0] & mask[13:0];
                    r = descend(ptr_slots[DOUBLE_SLOT], part >> sh, LEVELS_DOUBLE);
                end
                else if (lb < top)
                begin
                    part     = lb - base3;
                    upper    = part >> sh;
                    next_idx = upper[13:0] & mask[13:0];
                    last_idx = part[13:0] & mask[13:0];
                    r = descend(ptr_slots[TRIPLE_SLOT], part >> (2 * sh), LEVELS_TRIPLE);
                end
                else
                    r = '{KIND_DONE, 32'd0, 14'd0, 1'b0, 1'b1};
            end
            MODE_WORD:
            begin
                // A returned word either ends the walk or names the next block.
                if (walk_levels != LEVELS_IDLE)
                begin
                    has = 1'b1;
                    if (walk_levels == LEVELS_SINGLE)
                        r = finished(v);
                    else if (v == 32'd0)
                        r = finished(32'd0);
                    else
                    begin
                        r = '{KIND_REQUEST, v, next_idx, 1'b0, 1'b0};
                        if (walk_levels == LEVELS_TRIPLE)
                        begin
                            next_idx    = last_idx;
                            walk_levels = LEVELS_DOUBLE;
                        end
                        else
                            walk_levels = LEVELS_SINGLE;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Offer one input beat, wait for it to be taken and queue its result.
    task automatic put_beat(input logic [1:0] m, input logic [3:0] s, input logic [31:0] v,
                            input bit typed = 1'b0, input bit typed_has = 1'b0,
                            input res_t typed_r = '0);
        bit   has;
        res_t r;
        while ($urandom_range(99) < gap_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push  <= 1'b1;
        mode  <= m;
        slot  <= s;
        value <= v;
        do
            @(posedge clk);
        while (full);
        resolve_beat(m, s, v, has, r);
        if (typed)
        begin
            has = typed_has;
            r   = typed_r;
        end
        if (has)
            pending_results.push_back(r);
        if (has || (m == MODE_LOAD && s < POINTER_SLOTS))
            beats_in++;
    endtask

    // Stop offering and let every expected result drain out.
    task automatic drain();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_block_size(input logic [2:0] lg);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= lg;
        @(posedge clk);
        cfg_we    <= 1'b0;
        blk_log    = lg;
    endtask

    function automatic logic [31:0] any_pointer();
        if ($urandom_range(7) == 0)
            return 32'd0;
        return $urandom;
    endfunction

    // One walk: a map request in a chosen range, then the pointer words it
    // asks for. A few walks are cut short or get a pointer load in between.
    task automatic run_walk();
        int unsigned sh;
        int unsigned roll;
        logic [63:0] per_blk;
        logic [63:0] b2;
        logic [63:0] b3;
        logic [63:0] b4;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] pick;
        bit          broken;
        sh      = 8 + ((blk_log > MAX_LOG) ? MAX_LOG : blk_log);
        per_blk = 64'd1 << sh;
        b2      = 64'(DIRECT_SLOTS_DEF) + per_blk;
        b3      = b2 + (per_blk << sh);
        b4      = b3 + (per_blk << (2 * sh));
        do
        begin
            roll = $urandom_range(99);
            if (roll < 15)
            begin
                lo = 64'd0;
                hi = 64'(DIRECT_SLOTS_DEF - 1);
            end
            else if (roll < 40)
            begin
                lo = 64'(DIRECT_SLOTS_DEF);
                hi = b2 - 64'd1;
            end
            else if (roll < 65)
            begin
                lo = b2;
                hi = b3 - 64'd1;
            end
            else if (roll < 90)
            begin
                lo = b3;
                hi = b4 - 64'd1;
            end
            else
            begin
                lo = b4;
                hi = 64'hFFFF_FFFF;
            end
            if (hi > 64'hFFFF_FFFF)
                hi = 64'hFFFF_FFFF;
        end
        while (lo > hi);

        // Favor the ends of the range.
        case ($urandom_range(3))
            0:       pick = lo;
            1:       pick = hi;
            default: pick = lo + ({$urandom, $urandom} % (hi - lo + 64'd1));
        endcase
        put_beat(MODE_MAP, 4'($urandom_range(15)), pick[31:0]);

        broken = ($urandom_range(9) == 0);
        while (walk_levels != LEVELS_IDLE)
        begin
            if (broken && $urandom_range(1) == 0)
                break;
            if ($urandom_range(9) == 0)
                put_beat(MODE_LOAD, 4'($urandom_range(15)), any_pointer());
            put_beat(MODE_WORD, 4'($urandom_range(15)), any_pointer());
        end
    endtask

    // Compare one popped result beat with the oldest expectation.
    task automatic check_result();
        res_t want;
        if (pending_results.size() == 0)
        begin
            flag_error($sformatf("result with none expected: kind %0d addr %h",
                                 kind, block_num));
            return;
        end
        want = pending_results.pop_front();
        results_seen++;
        if (want.kind == KIND_REQUEST)
            requests++;
        if (want.sparse)
            holes++;
        if (want.out_of_range)
            beyond++;
        if (kind !== want.kind)
            flag_error($sformatf("kind %0d, expected %0d", kind, want.kind));
        if (block_num !== want.block_num)
            flag_error($sformatf("block_num %h, expected %h", block_num,
                                 want.block_num));
        if (word_index !== want.word_index)
            flag_error($sformatf("word_index %0d, expected %0d", word_index,
                                 want.word_index));
        if (sparse !== want.sparse)
            flag_error($sformatf("sparse %0d, expected %0d", sparse, want.sparse));
        if (out_of_range !== want.out_of_range)
            flag_error($sformatf("out_of_range %0d, expected %0d", out_of_range,
                                 want.out_of_range));
    endtask

    // Result side: random pop gaps and one long hold-off to back up the block.
    // The hold-off starts only while the input side is offering beats.
    initial
    begin
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                check_result();
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else if (!held && push && results_seen >= HOLD_AFTER)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= gap_pct);
        end
    end

    // Input side: reset, directed table, then random phases per block size.
    initial
    begin
        int target;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            put_beat(DIRECTED[i].mode, DIRECTED[i].slot, DIRECTED[i].value,
                     DIRECTED[i].typed, DIRECTED[i].has_res, DIRECTED[i].res);

        // Fill every pointer slot before random mapping starts.
        for (int s = 0; s < POINTER_SLOTS; s++)
            put_beat(MODE_LOAD, 4'(s), any_pointer());

        for (int p = 0; p < 8; p++)
        begin
            set_block_size(SIZE_PLAN[p]);
            gap_pct = (p == CALM_PHASE) ? 0 : 8;
            target  = beats_in + PHASE_BEATS;
            while (beats_in < target)
            begin
                case ($urandom_range(19))
                    0, 1:    put_beat(MODE_LOAD, 4'($urandom_range(15)), any_pointer());
                    2:       put_beat(MODE_BAD, 4'($urandom_range(15)), $urandom);
                    3:       put_beat(MODE_WORD, 4'($urandom_range(15)), $urandom);
                    4:       put_beat(MODE_MAP, 4'($urandom_range(15)), $urandom);
                    default: run_walk();
                endcase
            end
        end
        gap_pct = 8;
        drain();

        $display("Covered %0d input beats and %0d results: %0d read requests, %0d holes,",
                 beats_in, results_seen, requests, holes);
        $display("%0d beyond triple reach, eight block size settings, one %0d-cycle stall.",
                 beyond, HOLD_CYCLES);
        if (errors == 0)
            $display("indirect_block_map_walker_test OK");
        else
            $display("indirect_block_map_walker_test NOT OK");
        $finish;
    end

endmodule
